>>> hw/rtl/toroidal_life_generation_core_defines.svh
// Assertion macros for the toroidal Life core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TOROIDAL_LIFE_GENERATION_CORE_DEFINES_SVH
`define TOROIDAL_LIFE_GENERATION_CORE_DEFINES_SVH

// same-cycle implication
`define TLG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tlg_pkg.sv
// Shared constants and types for the toroidal Life core.
// No dependencies.
package tlg_pkg;

  localparam int BOARD_COLS = 64;
  localparam int BOARD_ROWS = 32;

  localparam int COL_W = $clog2(BOARD_COLS);
  localparam int ROW_W = $clog2(BOARD_ROWS);
  // wide enough to compare any field index against a board size up to 256
  localparam int IDX_W = 9;
  localparam int CNT_W = 4;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [CNT_W-1:0] LIVE_BIRTH = CNT_W'(3);
  localparam logic [CNT_W-1:0] LIVE_KEEP  = CNT_W'(2);

  typedef logic [BOARD_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WMERGE,
    ST_RD,
    ST_FILL0,
    ST_FILL1,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/tlg_row_unit.sv
// Row evaluator: next generation of one board row from three old rows.
// Depends on tlg_pkg.
module tlg_row_unit
  import tlg_pkg::*;
(
  input  row_t prev_row,
  input  row_t cur_row,
  input  row_t nxt_row,
  output row_t new_row
);

  always_comb begin
    logic [COL_W-1:0] cl;
    logic [COL_W-1:0] cr;
    logic [CNT_W-1:0] n;
    new_row = '0;
    for (int c = 0; c < BOARD_COLS; c++) begin
      cl = (c == 0) ? COL_W'(BOARD_COLS - 1) : COL_W'(c - 1);
      cr = (c == BOARD_COLS - 1) ? '0 : COL_W'(c + 1);
      n = CNT_W'(prev_row[cl]) + CNT_W'(prev_row[c]) + CNT_W'(prev_row[cr])
        + CNT_W'(cur_row[cl])                       + CNT_W'(cur_row[cr])
        + CNT_W'(nxt_row[cl])  + CNT_W'(nxt_row[c])  + CNT_W'(nxt_row[cr]);
      new_row[c] = (n == LIVE_BIRTH) | ((n == LIVE_KEEP) & cur_row[c]);
    end
  end

endmodule

>>> hw/rtl/toroidal_life_generation_core.sv
// Channel | dir | tvalid/tready handshake | payload
// in_     | in  | in_tvalid / in_tready   | in_tdata: col, row, cell_in; in_tuser: cmd
// out_    | out | out_tvalid / out_tready | out_tdata: cell_out; out_tuser: generation_done
//
// Step request: FILL0 and FILL1 load the old last row and row 0; SWEEP then runs
// the single row evaluator doing one row per cycle off the one read port of the board.
// Write request: read-modify-write of one row. Read request: waits for the output to free.
// Requests are taken one at a time, only in idle; a result waits in the output register.
// Reset clears the control state and the per-row valid bits (board reads as all dead).
// Depends on tlg_pkg, tlg_row_unit and the defines header.
`include "toroidal_life_generation_core_defines.svh"

module toroidal_life_generation_core
  import tlg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [5:0] col, [10:6] row, [11] cell_in
  input  logic [1:0]            in_tuser,   // [1:0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] cell_out
  output logic [0:0]            out_tuser   // [0] generation_done
);

  state_t state_r, state_nxt;

  logic [COL_W-1:0] req_col_r, req_col_nxt;
  logic [ROW_W-1:0] req_row_r, req_row_nxt;
  logic             req_val_r, req_val_nxt;
  logic             req_on_r, req_on_nxt;
  logic [ROW_W-1:0] sweep_row_r, sweep_row_nxt;
  row_t             prev_r, prev_nxt;
  row_t             cur_r, cur_nxt;
  row_t             row0_r, row0_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             out_cell_r, out_cell_nxt;
  logic             out_done_r, out_done_nxt;

  row_t                  board_mem [BOARD_ROWS];
  logic [BOARD_ROWS-1:0] row_valid_r;
  row_t                  rd_data_r;
  logic                  rd_valid_r;
  row_t                  rd_word;
  logic [ROW_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [ROW_W-1:0]      wr_addr;
  row_t                  wr_data;
  row_t                  merged_row;
  row_t                  nxt_row;
  row_t                  new_row;

  logic [IDX_W-1:0] in_col_ext;
  logic [IDX_W-1:0] in_row_ext;
  logic             in_on_board;
  logic             sweep_last;
  logic             out_free;
  cmd_t             in_cmd;

  assign in_col_ext  = IDX_W'(in_tdata[5:0]);
  assign in_row_ext  = IDX_W'(in_tdata[10:6]);
  assign in_on_board = (in_col_ext < IDX_W'(BOARD_COLS)) && (in_row_ext < IDX_W'(BOARD_ROWS));
  assign in_cmd      = cmd_t'(in_tuser);

  // rows never written since reset read as dead
  assign rd_word    = rd_valid_r ? rd_data_r : '0;
  assign sweep_last = (sweep_row_r == ROW_W'(BOARD_ROWS - 1));
  // last row wraps onto the saved old row 0, already overwritten in memory
  assign nxt_row    = sweep_last ? row0_r : rd_word;
  assign out_free   = !out_tvalid_r || out_tready;

  tlg_row_unit u_row_unit (
    .prev_row (prev_r),
    .cur_row  (cur_r),
    .nxt_row  (nxt_row),
    .new_row  (new_row)
  );

  always_comb begin
    merged_row            = rd_word;
    merged_row[req_col_r] = req_val_r;
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    req_col_nxt    = req_col_r;
    req_row_nxt    = req_row_r;
    req_val_nxt    = req_val_r;
    req_on_nxt     = req_on_r;
    sweep_row_nxt  = sweep_row_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    row0_nxt       = row0_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_cell_nxt   = out_cell_r;
    out_done_nxt   = out_done_r;
    rd_addr        = req_row_r;
    wr_en          = 1'b0;
    wr_addr        = sweep_row_r;
    wr_data        = new_row;

    unique case (state_r)
      ST_IDLE: begin
        rd_addr = in_row_ext[ROW_W-1:0];
        if (in_tvalid) begin
          req_col_nxt = in_col_ext[COL_W-1:0];
          req_row_nxt = in_row_ext[ROW_W-1:0];
          req_val_nxt = in_tdata[11];
          req_on_nxt  = in_on_board;
          unique case (in_cmd)
            CMD_WRITE: begin
              if (in_on_board) state_nxt = ST_WMERGE;
            end
            CMD_STEP: begin
              rd_addr   = ROW_W'(BOARD_ROWS - 1);
              state_nxt = ST_FILL0;
            end
            CMD_READ: state_nxt = ST_RD;
            default: ;
          endcase
        end
      end
      ST_WMERGE: begin
        wr_en     = 1'b1;
        wr_addr   = req_row_r;
        wr_data   = merged_row;
        state_nxt = ST_IDLE;
      end
      ST_RD: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_cell_nxt   = req_on_r & rd_word[req_col_r];
          out_done_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      ST_FILL0: begin
        prev_nxt  = rd_word;
        rd_addr   = '0;
        state_nxt = ST_FILL1;
      end
      ST_FILL1: begin
        cur_nxt       = rd_word;
        row0_nxt      = rd_word;
        rd_addr       = ROW_W'(1);
        sweep_row_nxt = '0;
        state_nxt     = ST_SWEEP;
      end
      ST_SWEEP: begin
        wr_en    = 1'b1;
        prev_nxt = cur_r;
        cur_nxt  = nxt_row;
        rd_addr  = (sweep_row_r >= ROW_W'(BOARD_ROWS - 2)) ? '0 : sweep_row_r + ROW_W'(2);
        if (sweep_last) begin
          sweep_row_nxt = '0;
          state_nxt     = ST_DONE;
        end else begin
          sweep_row_nxt = sweep_row_r + ROW_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_cell_nxt   = 1'b0;
          out_done_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sweep_row_r  <= '0;
      out_tvalid_r <= 1'b0;
      row_valid_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      sweep_row_r  <= sweep_row_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (wr_en) row_valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    req_col_r  <= req_col_nxt;
    req_row_r  <= req_row_nxt;
    req_val_r  <= req_val_nxt;
    req_on_r   <= req_on_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    row0_r     <= row0_nxt;
    out_cell_r <= out_cell_nxt;
    out_done_r <= out_done_nxt;
  end

  // board memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) board_mem[wr_addr] <= wr_data;
    rd_data_r  <= board_mem[rd_addr];
    rd_valid_r <= row_valid_r[rd_addr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'(out_cell_r);
  assign out_tuser  = out_done_r;

  `TLG_ASSERT_IMP(a_sweep_idle_zero, state_r != ST_SWEEP, sweep_row_r == '0, "row counter not at zero outside sweep")
  `TLG_ASSERT_IMP(a_write_states, wr_en, (state_r == ST_SWEEP) || (state_r == ST_WMERGE), "board written outside sweep or merge")
  `TLG_ASSERT_NXT(a_step_start, in_tvalid && in_tready && (in_tuser == CMD_STEP), state_r == ST_FILL0, "step request did not start fill")
  `TLG_ASSERT_NXT(a_sweep_end, (state_r == ST_SWEEP) && sweep_last, state_r == ST_DONE, "sweep did not end after last row")
  `TLG_ASSERT_NXT(a_done_result, (state_r == ST_DONE) && out_free, out_tvalid && out_tuser[0] && !out_tdata[0], "step completion not presented")

endmodule
